### rtl/md5_stream_hasher_defines.svh
// Assertion macros for the MD5 stream hasher.
// Needs clk and arst_n in the scope of use; empty bodies under SYNTHESIS.
`ifndef MD5_STREAM_HASHER_DEFINES_SVH
`define MD5_STREAM_HASHER_DEFINES_SVH
`ifndef SYNTHESIS
// cond must never hold outside reset
`define MD5_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
// ante implies cons in the same cycle
`define MD5_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// ante implies cons in the next cycle
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MD5_ASSERT_NEVER(lbl, cond, msg)
`define MD5_ASSERT_IMPLY(lbl, ante, cons, msg)
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/md5_pkg.sv
// Constants, round tables, sequencer states and round helpers for the MD5 hasher.
// Standalone package; used by md5_stream_hasher.
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

	localparam int BLOCK_WORDS = 16;
	localparam int POS_W       = $clog2(BLOCK_WORDS);
	localparam int ROUNDS      = 64;
	localparam int ROUND_W     = $clog2(ROUNDS);

	localparam logic [7:0]  PAD_BYTE = 8'h80;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;

	// Round-group selector (round index bits 5:4)
	localparam logic [1:0] GRP_F = 2'd0;
	localparam logic [1:0] GRP_G = 2'd1;
	localparam logic [1:0] GRP_H = 2'd2;

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_AMOUNT [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_FOLD,
		ST_PAD,
		ST_DONE
	} state_t;

	// Message word index used by a round
	function automatic logic [POS_W-1:0] md5_g(input logic [ROUND_W-1:0] r);
		logic [3:0] i;
		logic [3:0] g;
		i = r[3:0];
		case (r[5:4])
			GRP_F:   g = i;
			GRP_G:   g = 4'(i * 4'd5 + 4'd1);
			GRP_H:   g = 4'(i * 4'd3 + 4'd5);
			default: g = 4'(i * 4'd7);
		endcase
		return g;
	endfunction

	// Left-rotate amount used by a round
	function automatic logic [4:0] md5_rot(input logic [ROUND_W-1:0] r);
		return ROT_AMOUNT[{r[5:4], r[1:0]}];
	endfunction

	// Nonlinear mixing function of a round group
	function automatic logic [31:0] md5_f(input logic [1:0] grp, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (grp)
			GRP_F:   f = (b & c) | (~b & d);
			GRP_G:   f = (b & d) | (c & ~d);
			GRP_H:   f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		return f;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		return (x << s) | (x >> (6'd32 - {1'b0, s}));
	endfunction

endpackage

`default_nettype wire

### rtl/md5_stream_hasher.sv
// Streaming MD5 hasher: word buffer memory, single-round compression datapath,
// padding sequencer and digest output register. Depends on md5_pkg and the defines header.
//
//  channel | dir | fields (tdata low bit up)                 | marker
//  s_*     | in  | data_word[31:0], byte_count[34:32], zeros | s_tlast = last
//  m_*     | out | digest_word0..digest_word3 (32 bits each) | none
//
// A word that does not fill the block is written to the buffer. The word that fills it
// starts a compression: 1 buffer prefetch, 64 rounds on the one round unit
// (one buffer read per round), 1 chaining fold. A last word adds up to 18 pad
// writes, one or two compressions and a load of the digest register.
// Reset clears control and chaining state at once; the buffer needs no clearing.
// The next message may stream in while a digest waits; a new digest waits for the slot.
`timescale 1ns / 1ps
`default_nettype none
`include "md5_stream_hasher_defines.svh"

module md5_stream_hasher
	import md5_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [39:0]  s_tdata,   // data_word[31:0], byte_count[34:32], zero[39:35]
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata    // digest_word0..digest_word3, 32 bits each
);

	localparam logic [POS_W-1:0]   POS_LAST   = POS_W'(BLOCK_WORDS - 1);
	localparam logic [POS_W-1:0]   POS_LEN_LO = POS_W'(BLOCK_WORDS - 2);
	localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);

	state_t state_q, state_d;

	logic [POS_W-1:0]   pos_q;
	logic [60:0]        bytes_q;
	logic [31:0]        chain_q [4];
	logic [31:0]        a_q, b_q, c_q, d_q;
	logic [ROUND_W-1:0] round_q;
	logic               padding_q, pend80_q, lo_done_q, final_q;
	logic               m_tvalid_q;
	logic [127:0]       m_tdata_q;

	logic [31:0]        buf_mem [BLOCK_WORDS];
	logic [31:0]        rd_data_q;
	logic [POS_W-1:0]   rd_addr;
	logic               wr_en;
	logic [31:0]        wr_data;
	logic               digest_load;
	logic               accept;

	logic [31:0]        in_word;
	logic [2:0]         in_count;
	logic [2:0]         eff_count;
	logic [31:0]        last_word;
	logic [63:0]        bit_len;
	logic [31:0]        round_f;
	logic [31:0]        round_sum;
	logic [31:0]        round_b;

	// Decode the input item
	assign in_word   = s_tdata[31:0];
	assign in_count  = s_tdata[34:32];
	assign eff_count = (!s_tlast || in_count > 3'd4) ? 3'd4 : in_count;
	assign accept    = s_tvalid && s_tready;
	assign bit_len   = {bytes_q, 3'b000};

	// Mask invalid bytes of the last word and place the pad byte just above the valid ones
	always_comb begin
		case (eff_count)
			3'd0:    last_word = {24'h0, PAD_BYTE};
			3'd1:    last_word = {16'h0, PAD_BYTE, in_word[7:0]};
			3'd2:    last_word = {8'h0, PAD_BYTE, in_word[15:0]};
			3'd3:    last_word = {PAD_BYTE, in_word[23:0]};
			default: last_word = in_word;
		endcase
	end

	// One MD5 round on the working words
	assign round_f   = md5_f(round_q[5:4], b_q, c_q, d_q);
	assign round_sum = a_q + round_f + ROUND_K[round_q] + rd_data_q;
	assign round_b   = b_q + rotl32(round_sum, md5_rot(round_q));

	// Sequencer: next state, buffer port control
	always_comb begin
		state_d     = state_q;
		wr_en       = 1'b0;
		wr_data     = in_word;
		rd_addr     = md5_g(round_q + 1'b1);
		digest_load = 1'b0;
		s_tready    = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					wr_en   = 1'b1;
					wr_data = s_tlast ? last_word : in_word;
					if (pos_q == POS_LAST) begin
						state_d = ST_LOAD;
					end else if (s_tlast) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_LOAD: begin
				rd_addr = md5_g('0);
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (round_q == ROUND_LAST) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (final_q) begin
					state_d = ST_DONE;
				end else if (padding_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PAD: begin
				wr_en = 1'b1;
				if (pend80_q) begin
					wr_data = {24'h0, PAD_BYTE};
				end else if (pos_q == POS_LEN_LO && !lo_done_q) begin
					wr_data = bit_len[31:0];
				end else if (pos_q == POS_LAST && lo_done_q) begin
					wr_data = bit_len[63:32];
				end else begin
					wr_data = '0;
				end
				if (pos_q == POS_LAST) begin
					state_d = ST_LOAD;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					digest_load = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Buffer memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_mem[pos_q] <= wr_data;
		end
		rd_data_q <= buf_mem[rd_addr];
	end

	// Working words: load from chain, advance one round per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (state_q == ST_RUN) begin
			a_q <= d_q;
			b_q <= round_b;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	// Digest payload register
	always_ff @(posedge clk) begin
		if (digest_load) begin
			m_tdata_q <= {chain_q[3], chain_q[2], chain_q[1], chain_q[0]};
		end
	end

	// Control, counters and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '0;
			bytes_q    <= '0;
			round_q    <= '0;
			padding_q  <= 1'b0;
			pend80_q   <= 1'b0;
			lo_done_q  <= 1'b0;
			final_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			chain_q[0] <= INIT_A;
			chain_q[1] <= INIT_B;
			chain_q[2] <= INIT_C;
			chain_q[3] <= INIT_D;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				pos_q <= pos_q + 1'b1;
			end
			// Count bytes and arm the pad sequence
			if (state_q == ST_IDLE && accept) begin
				bytes_q <= bytes_q + 61'(eff_count);
				if (s_tlast) begin
					padding_q <= 1'b1;
					pend80_q  <= (eff_count == 3'd4);
					lo_done_q <= 1'b0;
				end
			end
			// Track the pad sequence
			if (state_q == ST_PAD) begin
				if (pend80_q) begin
					pend80_q <= 1'b0;
				end else if (pos_q == POS_LEN_LO && !lo_done_q) begin
					lo_done_q <= 1'b1;
				end else if (pos_q == POS_LAST && lo_done_q) begin
					final_q   <= 1'b1;
					padding_q <= 1'b0;
				end
			end
			if (state_q == ST_RUN) begin
				round_q <= round_q + 1'b1;
			end
			// Fold the working words into the chain
			if (state_q == ST_FOLD) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
			end
			// Hand off the digest and start a fresh message
			if (digest_load) begin
				m_tvalid_q <= 1'b1;
				final_q    <= 1'b0;
				bytes_q    <= '0;
				chain_q[0] <= INIT_A;
				chain_q[1] <= INIT_B;
				chain_q[2] <= INIT_C;
				chain_q[3] <= INIT_D;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Checks
	`MD5_ASSERT_NEVER(a_no_wr_in_run, wr_en && (state_q == ST_LOAD || state_q == ST_RUN), "buffer written during compression")
	`MD5_ASSERT_IMPLY(a_full_block, state_q == ST_LOAD, pos_q == '0 && round_q == '0, "compression started on partial block")
	`MD5_ASSERT_NEXT(a_digest_hold, state_q == ST_DONE && m_tvalid && !m_tready, state_q == ST_DONE && $stable(m_tdata), "digest overwritten while pending")
	`MD5_ASSERT_NEXT(a_fold_after_run, state_q == ST_RUN && round_q == ROUND_LAST, state_q == ST_FOLD, "fold skipped after last round")

endmodule

`default_nettype wire

### sim/md5_stream_hasher_test.sv
// Self-checking testbench for md5_stream_hasher: streams messages as 32-bit words and
// compares every digest with a behavioral MD5 predictor held in this file.
// Depends on md5_pkg and the md5_stream_hasher RTL.
`timescale 1ns / 1ps

module md5_stream_hasher_test;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          SETTLE_CYCLES = 200;
	localparam int          RANDOM_ITEMS = 500;
	localparam int          RANDOM_DIGESTS = 40;
	localparam logic [2:0]  FULL_COUNT = 3'd4;
	localparam logic [31:0] PAD_WORD = 32'h0000_0080;

	// Per-round additive constants and rotate amounts of MD5
	localparam logic [31:0] SINE_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int SHIFT_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [39:0]  s_tdata = '0;   // data_word[31:0], byte_count[34:32], zero[39:35]
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;        // digest_word0..digest_word3, 32 bits each

	md5_stream_hasher i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: chaining words, block buffer, fill position, byte length
	logic [31:0] hash_a, hash_b, hash_c, hash_d;
	logic [31:0] block_words [md5_pkg::BLOCK_WORDS];
	logic [3:0]  fill_pos;
	logic [60:0] byte_total;

	logic [127:0] pending_digests [$];
	int           mismatch_count = 0;
	int           digests_seen = 0;
	int           cycle_count = 0;
	int           burst_left = 0;
	int           rx_stall_left = 0;
	int           rx_calm_left = 0;

	function automatic logic [31:0] rol32(input logic [31:0] x, input int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic void md5_restart();
		hash_a = 32'h67452301;
		hash_b = 32'hefcdab89;
		hash_c = 32'h98badcfe;
		hash_d = 32'h10325476;
		fill_pos = '0;
		byte_total = '0;
	endfunction

	// Run the 64 rounds on the full buffer and fold into the chaining words
	function automatic void md5_compress();
		logic [31:0] a, b, c, d, f, sum, nb;
		int g;
		int grp;
		a = hash_a;
		b = hash_b;
		c = hash_c;
		d = hash_d;
		for (int i = 0; i < 64; i++) begin
			grp = i / 16;
			case (grp)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			sum = a + f + SINE_K[i] + block_words[g];
			nb = b + rol32(sum, SHIFT_S[grp * 4 + i % 4]);
			a = d;
			d = c;
			c = b;
			b = nb;
		end
		hash_a = hash_a + a;
		hash_b = hash_b + b;
		hash_c = hash_c + c;
		hash_d = hash_d + d;
	endfunction

	function automatic void md5_put(input logic [31:0] w);
		block_words[fill_pos] = w;
		fill_pos = fill_pos + 4'd1;
		if (fill_pos == 4'd0)
			md5_compress();
	endfunction

	// Absorb one word; on the last word pad, append the length and return the digest
	function automatic bit md5_absorb_word(input logic [31:0] data, input logic [2:0] count,
			input logic last, output logic [127:0] digest);
		logic [2:0]  n;
		logic [31:0] keep;
		logic [63:0] bit_len;
		digest = '0;
		n = (count > FULL_COUNT || !last) ? FULL_COUNT : count;
		if (!last) begin
			byte_total = byte_total + 61'd4;
			md5_put(data);
			return 1'b0;
		end
		byte_total = byte_total + 61'(n);
		if (n < FULL_COUNT) begin
			keep = (32'h1 << (8 * n)) - 32'h1;
			md5_put((data & keep) | (PAD_WORD << (8 * n)));
		end else begin
			md5_put(data);
			md5_put(PAD_WORD);
		end
		if (fill_pos > 4'd14) begin
			while (fill_pos != 4'd0)
				md5_put('0);
		end
		while (fill_pos < 4'd14)
			md5_put('0);
		bit_len = {byte_total, 3'b000};
		md5_put(bit_len[31:0]);
		md5_put(bit_len[63:32]);
		digest = {hash_d, hash_c, hash_b, hash_a};
		md5_restart();
		return 1'b1;
	endfunction

	// Send one item: idle between some bursts, hold until accepted, then predict
	task automatic send_word(input logic [31:0] data, input logic [2:0] count, input logic last);
		logic [127:0] digest;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, count, data};
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		if (md5_absorb_word(data, count, last, digest))
			pending_digests.push_back(digest);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every predicted digest has come out
	task automatic wait_digests_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_digests.size() != 0)
			@(negedge clk);
	endtask

	// Empty message, partial last words, full last word, saturated counts
	task automatic test_single_word_messages();
		send_word(32'hffff_ffff, 3'd0, 1'b1);
		send_word(32'haa63_6261, 3'd3, 1'b1);
		send_word(32'hffff_ffff, 3'd1, 1'b1);
		send_word(32'hffff_ffff, 3'd2, 1'b1);
		send_word(32'h0000_0000, 3'd4, 1'b1);
		send_word(32'hffff_ffff, 3'd4, 1'b1);
		send_word(32'h1234_5678, 3'd5, 1'b1);
		send_word(32'h9abc_def0, 3'd7, 1'b1);
	endtask

	// Short and oversized counts on inner words must count as full words
	task automatic test_odd_counts_mid_message();
		send_word(32'h0102_0304, 3'd0, 1'b0);
		send_word(32'h0506_0708, 3'd3, 1'b0);
		send_word(32'h090a_0b0c, 3'd6, 1'b0);
		send_word(32'hffff_ffff, 3'd7, 1'b0);
		send_word(32'hdead_beef, 3'd2, 1'b1);
	endtask

	// Last word with no bytes after a full word, and an all-ones tail
	task automatic test_empty_tail_word();
		send_word(32'h0000_0000, 3'd4, 1'b0);
		send_word(32'hffff_ffff, 3'd0, 1'b1);
		send_word(32'hffff_ffff, 3'd4, 1'b0);
		send_word(32'hffff_ffff, 3'd6, 1'b1);
	endtask

	// Random messages, biased to lengths around block boundaries
	task automatic test_random_messages();
		int items;
		int first_digest;
		int len;
		bit paused;
		logic [31:0] data;
		logic [2:0]  count;
		items = 0;
		first_digest = digests_seen + pending_digests.size();
		paused = 1'b0;
		while (items < RANDOM_ITEMS ||
				digests_seen + pending_digests.size() - first_digest < RANDOM_DIGESTS) begin
			case ($urandom_range(0, 3))
				0: len = $urandom_range(1, 8);
				1: len = (($urandom_range(0, 1) == 0) ? 16 : 32) + $urandom_range(0, 4) - 3;
				2: len = $urandom_range(1, 40);
				default: len = $urandom_range(1, 3);
			endcase
			for (int w = 0; w < len; w++) begin
				case ($urandom_range(0, 9))
					0: data = '0;
					1: data = '1;
					default: data = $urandom;
				endcase
				if (w == len - 1)
					count = 3'($urandom_range(0, 7));
				else if ($urandom_range(0, 7) == 0)
					count = 3'($urandom_range(0, 7));
				else
					count = FULL_COUNT;
				send_word(data, count, w == len - 1);
				items++;
			end
			// pause once midway until the output side has caught up
			if (!paused && items >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				wait_digests_drained();
			end
		end
	endtask

	// Receiver: random stalls with calm stretches of steady ready
	always @(negedge clk) begin
		if (rx_calm_left > 0) begin
			m_tready <= 1'b1;
			rx_calm_left <= rx_calm_left - 1;
		end else if (rx_stall_left > 0) begin
			m_tready <= 1'b0;
			rx_stall_left <= rx_stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			case ($urandom_range(0, 9))
				0, 1: rx_stall_left <= $urandom_range(1, 30);
				2: rx_calm_left <= $urandom_range(50, 400);
				default: ;
			endcase
		end
	end

	// Compare each accepted digest with the oldest prediction
	always @(posedge clk) begin
		logic [127:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			digests_seen++;
			if (pending_digests.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected digest %h", m_tdata);
			end else begin
				want = pending_digests.pop_front();
				for (int k = 0; k < 4; k++) begin
					if (m_tdata[32*k +: 32] !== want[32*k +: 32]) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("digest %0d word%0d: expected %h, got %h",
								digests_seen, k, want[32*k +: 32], m_tdata[32*k +: 32]);
					end
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		md5_restart();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_single_word_messages();
		test_odd_counts_mid_message();
		test_empty_tail_word();
		test_random_messages();
		wait_digests_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_digests.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
